FILE: sv/aopt_pkg.sv
// Shared constants, register codes and the arctangent table of the pose tracker.
package aopt_pkg;

   localparam int DATA_W = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_H_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_V_OFFSET = 2'd1;

   localparam logic [33:0] Q30_PI = 34'd3373259426;
   localparam logic [33:0] Q30_HALF_PI = 34'd1686629713;
   localparam logic [33:0] Q30_TWO_PI = 34'd6746518852;
   localparam logic [31:0] Q30_GAIN = 32'd652032874;

   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0: v = 30'd843314856;
         5'd1: v = 30'd497837829;
         5'd2: v = 30'd263043836;
         5'd3: v = 30'd133525158;
         5'd4: v = 30'd67021686;
         5'd5: v = 30'd33543515;
         5'd6: v = 30'd16775850;
         5'd7: v = 30'd8388437;
         5'd8: v = 30'd4194282;
         5'd9: v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/aopt_req_if.sv
// Sample channel: wheel distances and heading.
interface aopt_req_if;
   logic valid;
   logic ready;
   logic signed [aopt_pkg::DATA_W-1:0] vertical_distance;
   logic signed [aopt_pkg::DATA_W-1:0] horizontal_distance;
   logic signed [aopt_pkg::DATA_W-1:0] heading_reading;
   modport source(output valid, vertical_distance, horizontal_distance, heading_reading,
                  input ready);
   modport sink(input valid, vertical_distance, horizontal_distance, heading_reading,
                output ready);
endinterface

FILE: sv/aopt_rsp_if.sv
// Pose channel: updated position and heading.
interface aopt_rsp_if;
   logic valid;
   logic ready;
   logic signed [aopt_pkg::DATA_W-1:0] position_x;
   logic signed [aopt_pkg::DATA_W-1:0] position_y;
   logic signed [aopt_pkg::DATA_W-1:0] heading_out;
   modport source(output valid, position_x, position_y, heading_out, input ready);
   modport sink(input valid, position_x, position_y, heading_out, output ready);
endinterface

FILE: sv/arc_odometry_pose_tracker.sv
// Top level of the arc odometry pose tracker.
// Usage:
//  req_ch carries one sample word: vertical and horizontal wheel travel and the
//  absolute heading. rsp_ch returns one pose word per sample: x, y and heading.
//  csr_we/csr_index/csr_data write the wheel offsets (0 sideways, 1 forward);
//  write them only while no sample is in flight.
//  One sample at a time. A sample runs the shared CORDIC twice, overlapping
//  both serial dividers, then three rounds on two bit-serial multipliers (two
//  when the heading does not change), plus the sequencing states; the serial
//  CORDIC and multipliers do most of the work of each sample.
//  Reset clears the pose, the stored wheel readings and the offsets.
//  The result sits in an output register; the next sample is taken while it
//  waits. If rsp_ch stalls when a new pose is done, the sequencer holds it
//  until the register frees.
module arc_odometry_pose_tracker #(
   parameter int FRAC_BITS = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   aopt_req_if.sink                       req_ch,
   aopt_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [aopt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [aopt_pkg::DATA_W-1:0]    csr_data
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CORD1 = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_CHORD = 3'd3;
   localparam logic [2:0] S_ROT1 = 3'd4;
   localparam logic [2:0] S_ROT2 = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [31:0] off_h_ff, off_v_ff, last_v_ff, last_h_ff;
   logic [31:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in, pose_heading_ff, pose_heading_in;
   logic [31:0] head_ff, dh_ff, dv_ff, mean_ff, s_half_ff, lx_ff, ly_ff, lx_in, ly_in;
   logic        dt_zero_ff;
   logic [64:0] accx_ff, accx_in, diff;
   logic        rsp_valid_ff, rsp_valid_in, out_load;
   logic [31:0] out_x_ff, out_y_ff, out_h_ff;
   logic        accept;
   logic [31:0] dv_c, dh_c, dt_c, half_c, term_h, term_v;

   logic        cord_start, cord_busy;
   logic [31:0] cord_angle, cord_sin, cord_cos;
   logic        div_start, div0_busy, div1_busy;
   logic [31:0] div0_q, div1_q;
   logic        mul_start, mul0_busy, mul1_busy;
   logic [31:0] m0_a, m0_b, m1_a, m1_b;
   logic [63:0] p0, p1;

   aopt_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cord_start), .angle(cord_angle),
      .busy(cord_busy), .sin_q(cord_sin), .cos_q(cord_cos));
   aopt_div #(.FRAC_BITS(FRAC_BITS)) u_div_h (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dh_c), .divisor(dt_c),
      .busy(div0_busy), .quotient(div0_q));
   aopt_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dv_c), .divisor(dt_c),
      .busy(div1_busy), .quotient(div1_q));
   aopt_mul u_mul0 (
      .clock(clock), .reset(reset), .start(mul_start), .a(m0_a), .b(m0_b),
      .busy(mul0_busy), .product(p0));
   aopt_mul u_mul1 (
      .clock(clock), .reset(reset), .start(mul_start), .a(m1_a), .b(m1_b),
      .busy(mul1_busy), .product(p1));

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      dv_c = req_ch.vertical_distance - last_v_ff;
      dh_c = req_ch.horizontal_distance - last_h_ff;
      dt_c = req_ch.heading_reading - pose_heading_ff;
      half_c = {dt_c[31], dt_c[31:1]};
      term_h = div0_q + off_h_ff;
      term_v = div1_q + off_v_ff;
      diff = {p0[63], p0} - {p1[63], p1};
      out_load = 1'b0;
      state_in = state_ff;
      cord_start = 1'b0;
      cord_angle = half_c;
      div_start = 1'b0;
      mul_start = 1'b0;
      m0_a = lx_ff;
      m0_b = cord_cos;
      m1_a = ly_ff;
      m1_b = cord_sin;
      lx_in = lx_ff;
      ly_in = ly_ff;
      accx_in = accx_ff;
      pose_x_in = pose_x_ff;
      pose_y_in = pose_y_ff;
      pose_heading_in = pose_heading_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cord_start = 1'b1;
               div_start = 1'b1;
               state_in = S_CORD1;
            end
         end
         S_CORD1: begin
            if (!cord_busy) begin
               cord_start = 1'b1;
               cord_angle = mean_ff;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!cord_busy && !div0_busy && !div1_busy) begin
               mul_start = 1'b1;
               if (dt_zero_ff) begin
                  lx_in = dh_ff;
                  ly_in = dv_ff;
                  m0_a = dh_ff;
                  m1_a = dv_ff;
                  state_in = S_ROT1;
               end else begin
                  m0_a = term_h;
                  m0_b = s_half_ff;
                  m1_a = term_v;
                  m1_b = s_half_ff;
                  state_in = S_CHORD;
               end
            end
         end
         S_CHORD: begin
            if (!mul0_busy && !mul1_busy) begin
               lx_in = p0[60:29];
               ly_in = p1[60:29];
               m0_a = lx_in;
               m1_a = ly_in;
               mul_start = 1'b1;
               state_in = S_ROT1;
            end
         end
         S_ROT1: begin
            if (!mul0_busy && !mul1_busy) begin
               accx_in = {p0[63], p0} + {p1[63], p1};
               m0_a = ly_ff;
               m1_a = lx_ff;
               mul_start = 1'b1;
               state_in = S_ROT2;
            end
         end
         S_ROT2: begin
            if (!mul0_busy && !mul1_busy) begin
               pose_x_in = pose_x_ff + accx_ff[61:30];
               pose_y_in = pose_y_ff + diff[61:30];
               pose_heading_in = head_ff;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         off_h_ff <= '0;
         off_v_ff <= '0;
         last_v_ff <= '0;
         last_h_ff <= '0;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         pose_heading_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               aopt_pkg::CSR_H_OFFSET: off_h_ff <= csr_data;
               aopt_pkg::CSR_V_OFFSET: off_v_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            last_v_ff <= req_ch.vertical_distance;
            last_h_ff <= req_ch.horizontal_distance;
         end
         pose_x_ff <= pose_x_in;
         pose_y_ff <= pose_y_in;
         pose_heading_ff <= pose_heading_in;
      end
      if (accept) begin
         head_ff <= req_ch.heading_reading;
         dh_ff <= dh_c;
         dv_ff <= dv_c;
         dt_zero_ff <= (dt_c == '0);
         mean_ff <= pose_heading_ff + half_c;
      end
      if (state_ff == S_CORD1 && !cord_busy) s_half_ff <= cord_sin;
      lx_ff <= lx_in;
      ly_ff <= ly_in;
      accx_ff <= accx_in;
      if (out_load) begin
         out_x_ff <= pose_x_ff;
         out_y_ff <= pose_y_ff;
         out_h_ff <= pose_heading_ff;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.position_x = out_x_ff;
   assign rsp_ch.position_y = out_y_ff;
   assign rsp_ch.heading_out = out_h_ff;

   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         (!cord_busy && !div0_busy && !div1_busy && !mul0_busy && !mul1_busy))
      else $error("arithmetic unit busy while sequencer idle");
   a_head_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_ch.heading_out == pose_heading_ff))
      else $error("heading word does not match stored heading");
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_ch.valid && rsp_ch.position_x == pose_x_ff
                    && rsp_ch.position_y == pose_y_ff))
      else $error("pose word not loaded from stored pose");
endmodule

FILE: sv/aopt_div.sv
// Bit-serial restoring divider: (dividend * 2^FRAC_BITS) / divisor, truncated, low 32 bits.
module aopt_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);
   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] num_ff, num_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic          neg_ff, neg_in;
   logic [31:0]   q_ff, q_in;
   logic [32:0]   nd_ext, nd_abs, dd_ext, dd_abs, rs;
   logic          ge;

   always_comb begin
      nd_ext = {dividend[31], dividend};
      nd_abs = nd_ext[32] ? -nd_ext : nd_ext;
      dd_ext = {divisor[31], divisor};
      dd_abs = dd_ext[32] ? -dd_ext : dd_ext;
      rs = {rem_ff, num_ff[NW-1]};
      ge = rs >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      q_in = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CW'(NW);
         num_in = NW'(nd_abs) << FRAC_BITS;
         rem_in = '0;
         den_in = dd_abs[31:0];
         neg_in = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         rem_in = ge ? 32'(rs - {1'b0, den_ff}) : rs[31:0];
         num_in = {num_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            q_in = neg_ff ? -num_in[31:0] : num_in[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      q_ff <= q_in;
   end

   assign busy = busy_ff;
   assign quotient = q_ff;
endmodule

FILE: sv/aopt_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module aopt_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        busy,
   output logic [63:0] product
);
   logic               busy_ff, busy_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [31:0]        a_ff, a_in;
   logic signed [32:0] hi_ff, hi_in;
   logic [31:0]        lo_ff, lo_in;
   logic signed [32:0] a_ext, addend, t;

   always_comb begin
      a_ext = {a_ff[31], a_ff};
      addend = '0;
      if (lo_ff[0]) addend = (cnt_ff == 5'd31) ? -a_ext : a_ext;
      t = hi_ff + addend;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      a_in = a_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         a_in = a;
         hi_in = '0;
         lo_in = b;
      end else if (busy_ff) begin
         hi_in = {t[32], t[32:1]};
         lo_in = {t[0], lo_ff[31:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd31) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      a_ff <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign busy = busy_ff;
   assign product = {hi_ff[31:0], lo_ff};
endmodule

FILE: sv/aopt_cordic.sv
// Iterative CORDIC sine/cosine in Q30 with serial modulo-2pi range reduction.
module aopt_cordic #(
   parameter int FRAC_BITS = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] angle,
   output logic        busy,
   output logic [31:0] sin_q,
   output logic [31:0] cos_q
);
   localparam int MW = 63 - FRAC_BITS;
   localparam int RED_N = 30 - FRAC_BITS;
   localparam int RW = $clog2(RED_N + 1);
   localparam int IW = $clog2(CORDIC_STEPS);
   localparam int ZR = 36;
   localparam logic [MW-1:0] M0 = MW'(aopt_pkg::Q30_TWO_PI) << (RED_N - 1);
   localparam logic signed [ZR-1:0] ZPI = ZR'(aopt_pkg::Q30_PI);
   localparam logic signed [ZR-1:0] ZHPI = ZR'(aopt_pkg::Q30_HALF_PI);
   localparam logic signed [ZR-1:0] Z2PI = ZR'(aopt_pkg::Q30_TWO_PI);

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_RED = 2'd1;
   localparam logic [1:0] P_FOLD = 2'd2;
   localparam logic [1:0] P_ROT = 2'd3;

   logic [1:0]            ph_ff, ph_in;
   logic [RW-1:0]         rc_ff, rc_in;
   logic [IW-1:0]         i_ff, i_in;
   logic [MW-1:0]         r_ff, r_in, m_ff, m_in;
   logic                  neg_ff, neg_in, flip_ff, flip_in;
   logic signed [ZR-1:0]  z_ff, z_in, z0, z1;
   logic signed [31:0]    x_ff, x_in, y_ff, y_in, xs, ys;
   logic [31:0]           s_ff, s_in, c_ff, c_in;
   logic [32:0]           a_ext, a_abs;
   logic signed [ZR-1:0]  at;

   always_comb begin
      a_ext = {angle[31], angle};
      a_abs = a_ext[32] ? -a_ext : a_ext;
      z0 = neg_ff ? -ZR'(r_ff[33:0]) : ZR'(r_ff[33:0]);
      z1 = z0;
      if (z0 > ZPI) z1 = z0 - Z2PI;
      else if (z0 < -ZPI) z1 = z0 + Z2PI;
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      at = ZR'(aopt_pkg::atan_q30(5'(i_ff)));
      ph_in = ph_ff;
      rc_in = rc_ff;
      i_in = i_ff;
      r_in = r_ff;
      m_in = m_ff;
      neg_in = neg_ff;
      flip_in = flip_ff;
      z_in = z_ff;
      x_in = x_ff;
      y_in = y_ff;
      s_in = s_ff;
      c_in = c_ff;
      unique case (ph_ff)
         P_IDLE: begin
            if (start) begin
               ph_in = P_RED;
               rc_in = RW'(RED_N);
               r_in = MW'(a_abs) << (30 - FRAC_BITS);
               m_in = M0;
               neg_in = angle[31];
            end
         end
         P_RED: begin
            if (r_ff >= m_ff) r_in = r_ff - m_ff;
            m_in = m_ff >> 1;
            rc_in = rc_ff - 1'b1;
            if (rc_ff == RW'(1)) ph_in = P_FOLD;
         end
         P_FOLD: begin
            flip_in = 1'b0;
            z_in = z1;
            if (z1 > ZHPI) begin
               z_in = z1 - ZPI;
               flip_in = 1'b1;
            end else if (z1 < -ZHPI) begin
               z_in = z1 + ZPI;
               flip_in = 1'b1;
            end
            x_in = aopt_pkg::Q30_GAIN;
            y_in = '0;
            i_in = '0;
            ph_in = P_ROT;
         end
         P_ROT: begin
            if (!z_ff[ZR-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            i_in = i_ff + 1'b1;
            if (i_ff == IW'(CORDIC_STEPS - 1)) begin
               ph_in = P_IDLE;
               s_in = flip_ff ? -y_in : y_in;
               c_in = flip_ff ? -x_in : x_in;
            end
         end
         default: ph_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= P_IDLE;
      end else begin
         ph_ff <= ph_in;
      end
      rc_ff <= rc_in;
      i_ff <= i_in;
      r_ff <= r_in;
      m_ff <= m_in;
      neg_ff <= neg_in;
      flip_ff <= flip_in;
      z_ff <= z_in;
      x_ff <= x_in;
      y_ff <= y_in;
      s_ff <= s_in;
      c_ff <= c_in;
   end

   assign busy = (ph_ff != P_IDLE);
   assign sin_q = s_ff;
   assign cos_q = c_ff;
endmodule

FILE: dv/tb_arc_odometry_pose_tracker.sv
// Testbench for the arc odometry pose tracker: random and directed samples against a pose predictor.
`timescale 1ns / 1ps

class pose_scoreboard;
   typedef struct {
      bit [31:0] x;
      bit [31:0] y;
      bit [31:0] hd;
   } pose_type;

   localparam longint PI_Q30 = 64'd3373259426;
   localparam longint HALF_PI_Q30 = 64'd1686629713;
   localparam longint TWO_PI_Q30 = 64'd6746518852;
   localparam longint GAIN_Q30 = 64'd652032874;
   localparam int FRAC = 16;
   localparam int STEPS = 16;

   longint arctan[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

   bit [31:0] side_offset, fwd_offset;
   bit [31:0] prev_vert, prev_horiz, px, py, phead;
   pose_type poses_due[$];
   int mismatches;

   function longint sx(bit [31:0] v);
      return longint'(signed'(v));
   endfunction

   function void write_offset(bit [1:0] idx, bit [31:0] val);
      if (idx == aopt_pkg::CSR_H_OFFSET) side_offset = val;
      else if (idx == aopt_pkg::CSR_V_OFFSET) fwd_offset = val;
   endfunction

   function void sin_cos(bit [31:0] angle, output longint s, output longint c);
      longint z, x, y, nx;
      bit flip;
      z = sx(angle) * (64'sd1 <<< (30 - FRAC));
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      z = z % TWO_PI_Q30;
      if (z > PI_Q30) z -= TWO_PI_Q30;
      if (z < -PI_Q30) z += TWO_PI_Q30;
      if (z > HALF_PI_Q30) begin
         z -= PI_Q30;
         flip = 1;
      end else if (z < -HALF_PI_Q30) begin
         z += PI_Q30;
         flip = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= arctan[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += arctan[i];
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function longint arc_chord(longint delta, longint dt, bit [31:0] offs, longint sin_half);
      longint q, term;
      bit [31:0] qw, tw;
      q = (delta * (64'sd1 <<< FRAC)) / dt;
      qw = q[31:0];
      tw = qw + offs;
      term = sx(tw);
      return (term * sin_half) >>> 29;
   endfunction

   function void note_sample(bit [31:0] vert, bit [31:0] horiz, bit [31:0] head);
      longint dv, dh, dt, half, lx, ly, s, c, gx, gy;
      bit [31:0] w;
      pose_type p;
      w = vert - prev_vert;
      dv = sx(w);
      w = horiz - prev_horiz;
      dh = sx(w);
      w = head - phead;
      dt = sx(w);
      half = dt >>> 1;
      prev_vert = vert;
      prev_horiz = horiz;
      if (dt == 0) begin
         lx = dh;
         ly = dv;
      end else begin
         w = half[31:0];
         sin_cos(w, s, c);
         lx = arc_chord(dh, dt, side_offset, s);
         lx = sx(lx[31:0]);
         ly = arc_chord(dv, dt, fwd_offset, s);
         ly = sx(ly[31:0]);
      end
      w = phead + half[31:0];
      sin_cos(w, s, c);
      gx = (lx * c + ly * s) >>> 30;
      gy = (ly * c - lx * s) >>> 30;
      px = px + gx[31:0];
      py = py + gy[31:0];
      phead = head;
      p.x = px;
      p.y = py;
      p.hd = phead;
      poses_due.push_back(p);
   endfunction

   function void check_pose(bit [31:0] x, bit [31:0] y, bit [31:0] hd);
      pose_type p;
      if (poses_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected pose word x=%h y=%h hd=%h", x, y, hd);
         return;
      end
      p = poses_due.pop_front();
      if (p.x !== x || p.y !== y || p.hd !== hd) begin
         mismatches++;
         if (mismatches <= 10)
            $display("pose mismatch: exp x=%h y=%h hd=%h got x=%h y=%h hd=%h",
                     p.x, p.y, p.hd, x, y, hd);
      end
   endfunction
endclass

module tb_arc_odometry_pose_tracker;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [aopt_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [aopt_pkg::DATA_W-1:0] csr_data = '0;
   logic hold_off = 0;
   int cycles = 0;

   aopt_req_if req_if ();
   aopt_rsp_if rsp_if ();

   pose_scoreboard sb = new();
   bit [31:0] cur_vert, cur_horiz, cur_head;

   arc_odometry_pose_tracker dut (
      .clock(clock), .reset(reset), .req_ch(req_if.sink), .rsp_ch(rsp_if.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      req_if.valid = 0;
      req_if.vertical_distance = '0;
      req_if.horizontal_distance = '0;
      req_if.heading_reading = '0;
      rsp_if.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[arc_odometry_pose_tracker] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_pose(rsp_if.position_x, rsp_if.position_y, rsp_if.heading_out);
      if (hold_off) rsp_if.ready <= 0;
      else if ($urandom_range(0, 99) < 8) rsp_if.ready <= 0;
      else if ($urandom_range(0, 99) < 3) rsp_if.ready <= 0;
      else rsp_if.ready <= 1;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   task automatic send_sample(bit [31:0] v, bit [31:0] h, bit [31:0] hd);
      int gap;
      req_if.valid <= 1;
      req_if.vertical_distance <= v;
      req_if.horizontal_distance <= h;
      req_if.heading_reading <= hd;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      sb.note_sample(v, h, hd);
      cur_vert = v;
      cur_horiz = h;
      cur_head = hd;
      gap = pick_gap();
      if (gap != 0) begin
         req_if.valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      if (req_if.valid) begin
         req_if.valid <= 0;
         @(posedge clock);
      end
      while (sb.poses_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(bit [1:0] idx, bit [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      sb.write_offset(idx, val);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic random_sample();
      int r;
      bit [31:0] v, h, hd;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         v = cur_vert + 32'($signed($urandom_range(0, 20000)) - 10000);
         h = cur_horiz + 32'($signed($urandom_range(0, 20000)) - 10000);
         if ($urandom_range(0, 4) == 0) hd = cur_head;
         else hd = cur_head + 32'($signed($urandom_range(0, 262144)) - 131072);
      end else if (r < 85) begin
         v = cur_vert + 32'($signed($urandom_range(0, 2000000)) - 1000000);
         h = cur_horiz + 32'($signed($urandom_range(0, 2000000)) - 1000000);
         hd = cur_head + 32'($signed($urandom_range(0, 6)) - 3);
      end else begin
         v = $urandom();
         h = $urandom();
         hd = ($urandom_range(0, 3) == 0) ? cur_head : $urandom();
      end
      send_sample(v, h, hd);
   endtask

   initial begin
      bit [31:0] offs_h[5], offs_v[5];
      cur_vert = 0;
      cur_horiz = 0;
      cur_head = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_sample(32'd65536, 32'd32768, 32'd0);
      send_sample(32'd131072, 32'd0, 32'd6554);
      drain();
      write_csr(aopt_pkg::CSR_H_OFFSET, 32'h0003_0000);
      write_csr(aopt_pkg::CSR_V_OFFSET, 32'hFFFE_8000);
      send_sample(32'd200000, 32'd70000, 32'd20000);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(32'h0, 32'hFFFF_FFFF, 32'h8000_0001);
      send_sample(32'h7000_0000, 32'h9000_0000, 32'h8000_0002);
      send_sample(32'h1000_0000, 32'h1000_0000, 32'h8000_0001);
      send_sample(32'h1000_0000, 32'h1000_0000, 32'h8000_0001);
      send_sample(32'hFFFF_FFFF, 32'h0, 32'h0003_243F);
      send_sample(32'h0, 32'h0, 32'hFFFC_DBC1);
      send_sample(32'h0, 32'h0, 32'h0001_921F);
      send_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
      send_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
      drain();
      write_csr(2'd2, 32'hDEAD_BEEF);
      write_csr(2'd3, 32'h1234_5678);
      send_sample(32'h0001_0000, 32'h0001_0000, 32'h5555_6000);

      offs_h = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0005_0000, $urandom()};
      offs_v = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFB_8000, $urandom()};
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         write_csr(aopt_pkg::CSR_H_OFFSET, offs_h[ph]);
         write_csr(aopt_pkg::CSR_V_OFFSET, offs_v[ph]);
         for (int n = 0; n < 120; n++) begin
            if (ph == 2 && n == 30) begin
               hold_off = 1;
               fork
                  begin
                     repeat (3000) @(posedge clock);
                     hold_off = 0;
                  end
               join_none
            end
            if (n == 60) drain();
            random_sample();
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.poses_due.size() == 0)
         $display("[arc_odometry_pose_tracker] OK");
      else
         $display("[arc_odometry_pose_tracker] ERROR");
      $finish;
   end
endmodule
